// ----- rtl/pwmhl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the PWM high/low time extractor.
package pwmhl_pkg;

   // Number of monitored pins and widths of the capture fields
   localparam int PIN_COUNT    = 4;
   localparam int IVL_WIDTH    = 16;
   localparam int ACC_WIDTH    = 20;

   // Saturation value of a time accumulator
   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

   // Period tracker codes; the unused code behaves as done
   localparam logic [1:0] TRK_BEFORE = 2'd0;
   localparam logic [1:0] TRK_IN     = 2'd1;
   localparam logic [1:0] TRK_DONE   = 2'd2;

   // Times found by one pin lane
   typedef struct packed {
      logic [ACC_WIDTH-1:0] low_time;
      logic [ACC_WIDTH-1:0] high_time;
   } lane_result_type;

   typedef lane_result_type [PIN_COUNT-1:0] frame_result_type;

endpackage

// ----- rtl/pwmhl_req_if.sv -----
`timescale 1ns / 1ps
// Capture record channel: valid/ready handshake with one record per transfer.
interface pwmhl_req_if;
   logic        valid;
   logic        ready;
   logic        first_record;
   logic [3:0]  initial_pins;
   logic [15:0] interval_count;
   logic [3:0]  pin_values;
   logic        last_record;

   modport source (output valid, first_record, initial_pins, interval_count,
                   pin_values, last_record, input ready);
   modport sink   (input valid, first_record, initial_pins, interval_count,
                   pin_values, last_record, output ready);
endinterface

// ----- rtl/pwmhl_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying the four low and high times.
interface pwmhl_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] low_time_0;
   logic [19:0] high_time_0;
   logic [19:0] low_time_1;
   logic [19:0] high_time_1;
   logic [19:0] low_time_2;
   logic [19:0] high_time_2;
   logic [19:0] low_time_3;
   logic [19:0] high_time_3;

   modport source (output valid, low_time_0, high_time_0, low_time_1, high_time_1,
                   low_time_2, high_time_2, low_time_3, high_time_3, input ready);
   modport sink   (input valid, low_time_0, high_time_0, low_time_1, high_time_1,
                   low_time_2, high_time_2, low_time_3, high_time_3, output ready);
endinterface

// ----- rtl/pwmhl_lane.sv -----
`timescale 1ns / 1ps
// One pin lane: low/high period trackers and saturating time accumulators.
module pwmhl_lane
   import pwmhl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 first_record,
   input  logic                 init_pin,
   input  logic [IVL_WIDTH-1:0] interval_count,
   input  logic                 pin_now,
   output lane_result_type      next_result
);

   logic                 prev_pin_ff, prev_pin_in;
   logic [1:0]           low_trk_ff, low_trk_in;
   logic [1:0]           high_trk_ff, high_trk_in;
   logic [ACC_WIDTH-1:0] low_acc_ff, low_acc_in;
   logic [ACC_WIDTH-1:0] high_acc_ff, high_acc_in;

   logic                 prev_eff;
   logic [1:0]           low_trk_cur, high_trk_cur;
   logic [ACC_WIDTH-1:0] low_acc_cur, high_acc_cur;
   logic [ACC_WIDTH:0]   low_sum, high_sum;
   logic [ACC_WIDTH-1:0] low_sat, high_sat;
   logic                 fall, rise;

   // Start of frame: drop the old period and load the initial level
   assign prev_eff     = first_record ? init_pin   : prev_pin_ff;
   assign low_trk_cur  = first_record ? TRK_BEFORE : low_trk_ff;
   assign high_trk_cur = first_record ? TRK_BEFORE : high_trk_ff;
   assign low_acc_cur  = first_record ? '0 : low_acc_ff;
   assign high_acc_cur = first_record ? '0 : high_acc_ff;

   assign fall = prev_eff & ~pin_now;
   assign rise = ~prev_eff & pin_now;

   // Saturating adds of the interval
   assign low_sum  = {1'b0, low_acc_cur}
                   + {{(ACC_WIDTH+1-IVL_WIDTH){1'b0}}, interval_count};
   assign high_sum = {1'b0, high_acc_cur}
                   + {{(ACC_WIDTH+1-IVL_WIDTH){1'b0}}, interval_count};
   assign low_sat  = low_sum[ACC_WIDTH]  ? ACC_MAX : low_sum[ACC_WIDTH-1:0];
   assign high_sat = high_sum[ACC_WIDTH] ? ACC_MAX : high_sum[ACC_WIDTH-1:0];

   // Accumulate into whichever period is in progress, then advance trackers
   always_comb begin
      prev_pin_in = prev_pin_ff;
      low_trk_in  = low_trk_ff;
      high_trk_in = high_trk_ff;
      low_acc_in  = low_acc_ff;
      high_acc_in = high_acc_ff;
      if (accept) begin
         prev_pin_in = pin_now;
         low_acc_in  = (low_trk_cur == TRK_IN) ? low_sat : low_acc_cur;
         high_acc_in = (low_trk_cur != TRK_IN && high_trk_cur == TRK_IN) ?
                       high_sat : high_acc_cur;

         low_trk_in = low_trk_cur;
         unique case (low_trk_cur)
            TRK_BEFORE: begin
               if (fall) low_trk_in = TRK_IN;
            end
            TRK_IN: begin
               if (rise) low_trk_in = TRK_DONE;
            end
            default: begin
               low_trk_in = low_trk_cur;
            end
         endcase

         high_trk_in = high_trk_cur;
         unique case (high_trk_cur)
            TRK_BEFORE: begin
               if (rise) high_trk_in = TRK_IN;
            end
            TRK_IN: begin
               if (fall) high_trk_in = TRK_DONE;
            end
            default: begin
               high_trk_in = high_trk_cur;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pin_ff <= 1'b0;
         low_trk_ff  <= TRK_BEFORE;
         high_trk_ff <= TRK_BEFORE;
         low_acc_ff  <= '0;
         high_acc_ff <= '0;
      end else begin
         prev_pin_ff <= prev_pin_in;
         low_trk_ff  <= low_trk_in;
         high_trk_ff <= high_trk_in;
         low_acc_ff  <= low_acc_in;
         high_acc_ff <= high_acc_in;
      end
   end

   // Updated times, valid in the cycle of the transfer
   assign next_result.low_time  = low_acc_in;
   assign next_result.high_time = high_acc_in;

endmodule

// ----- rtl/pwmhl_merge.sv -----
`timescale 1ns / 1ps
// Merge stage: gathers the lane times into a two-entry result queue.
module pwmhl_merge
   import pwmhl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_result_type lane_results,
   output logic             space,
   pwmhl_rsp_if.source      rsp_chan
);

   frame_result_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;
   frame_result_type head;

   assign pop   = rsp_chan.valid & rsp_chan.ready;
   assign space = (count_ff != 2'd2);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold result payloads
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= lane_results;
      end
   end

   assign head                 = entry_ff[rd_ptr_ff];
   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.low_time_0  = head[0].low_time;
   assign rsp_chan.high_time_0 = head[0].high_time;
   assign rsp_chan.low_time_1  = head[1].low_time;
   assign rsp_chan.high_time_1 = head[1].high_time;
   assign rsp_chan.low_time_2  = head[2].low_time;
   assign rsp_chan.high_time_2 = head[2].high_time;
   assign rsp_chan.low_time_3  = head[3].low_time;
   assign rsp_chan.high_time_3 = head[3].high_time;

endmodule

// ----- rtl/pwm_high_low_time_extract.sv -----
`timescale 1ns / 1ps
// Top level of the four-pin PWM high/low time extractor.
//
//   channel   | dir | handshake           | payload
//   req_chan  | in  | valid/ready         | one capture record
//   rsp_chan  | out | valid/ready         | four low times, four high times
//
// One record is taken per clock while ready; the four lanes update then.
// A record marked last pushes the frame's times into a two-entry result
// queue; the result is offered from the next cycle on.
// req_chan.ready drops only while both queue entries wait to be taken.
// Synchronous reset clears trackers, accumulators, levels and the queue.
module pwm_high_low_time_extract
   import pwmhl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pwmhl_req_if.sink   req_chan,
   pwmhl_rsp_if.source rsp_chan
);

   logic             accept;
   logic             space;
   frame_result_type lane_results;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid & space;

   // One lane per pin
   for (genvar g = 0; g < PIN_COUNT; g++) begin : g_lane
      pwmhl_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .accept         (accept),
         .first_record   (req_chan.first_record),
         .init_pin       (req_chan.initial_pins[g]),
         .interval_count (req_chan.interval_count),
         .pin_now        (req_chan.pin_values[g]),
         .next_result    (lane_results[g])
      );
   end

   // Merge lane times into the result queue at the end of a frame
   pwmhl_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .push         (accept & req_chan.last_record),
      .lane_results (lane_results),
      .space        (space),
      .rsp_chan     (rsp_chan)
   );

endmodule

// ----- sim/pwm_high_low_time_extract_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the PWM high/low time extractor.
module pwm_high_low_time_extract_tb;
   import pwmhl_pkg::*;

   localparam int DIRECTED_ITEMS = 25;
   localparam int RANDOM_STOP    = DIRECTED_ITEMS + 1600;
   localparam int DRAIN_POINT    = 800;
   localparam int CYCLE_LIMIT    = 500000;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_SPARSE,
      STALL_LONG
   } stall_mode_type;

   // Predict frame times per record and hold them until the block returns them
   class frame_time_scoreboard;
      logic [PIN_COUNT-1:0] prev_levels;
      logic [1:0]           low_state [PIN_COUNT];
      logic [1:0]           high_state [PIN_COUNT];
      logic [ACC_WIDTH-1:0] low_sum [PIN_COUNT];
      logic [ACC_WIDTH-1:0] high_sum [PIN_COUNT];
      frame_result_type     expected_times [$];
      int unsigned          errors;

      function new();
         prev_levels = '0;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         for (int j = 0; j < PIN_COUNT; j++) begin
            low_state[j] = TRK_BEFORE;
            high_state[j] = TRK_BEFORE;
            low_sum[j] = '0;
            high_sum[j] = '0;
         end
      endfunction

      function logic [ACC_WIDTH-1:0] saturate_add(logic [ACC_WIDTH-1:0] acc,
                                                  logic [IVL_WIDTH-1:0] ivl);
         logic [ACC_WIDTH:0] sum;
         sum = acc + ivl;
         return sum[ACC_WIDTH] ? ACC_MAX : sum[ACC_WIDTH-1:0];
      endfunction

      function int pending();
         return expected_times.size();
      endfunction

      function void note_record(bit first, logic [PIN_COUNT-1:0] init,
                                logic [IVL_WIDTH-1:0] ivl,
                                logic [PIN_COUNT-1:0] levels, bit last);
         logic             was;
         logic             now;
         bit               fall;
         bit               rise;
         frame_result_type times;
         if (first) begin
            clear_frame();
            prev_levels = init;
         end
         for (int j = 0; j < PIN_COUNT; j++) begin
            was = prev_levels[j];
            now = levels[j];
            fall = was && !now;
            rise = !was && now;
            // accumulate the interval into whichever period is in progress
            if (low_state[j] == TRK_IN)
               low_sum[j] = saturate_add(low_sum[j], ivl);
            else if (high_state[j] == TRK_IN)
               high_sum[j] = saturate_add(high_sum[j], ivl);
            // advance the trackers on this record's edge
            if (low_state[j] == TRK_BEFORE && fall)
               low_state[j] = TRK_IN;
            else if (low_state[j] == TRK_IN && rise)
               low_state[j] = TRK_DONE;
            if (high_state[j] == TRK_BEFORE && rise)
               high_state[j] = TRK_IN;
            else if (high_state[j] == TRK_IN && fall)
               high_state[j] = TRK_DONE;
         end
         prev_levels = levels;
         if (last) begin
            for (int j = 0; j < PIN_COUNT; j++) begin
               times[j].low_time = low_sum[j];
               times[j].high_time = high_sum[j];
            end
            expected_times.push_back(times);
         end
      endfunction

      function void check_times(frame_result_type seen);
         frame_result_type want;
         if (expected_times.size() == 0) begin
            $error("result transfer with no expected frame times");
            errors++;
            return;
         end
         want = expected_times.pop_front();
         for (int j = 0; j < PIN_COUNT; j++) begin
            if (seen[j].low_time !== want[j].low_time) begin
               $error("low_time_%0d: expected %0d, actual %0d",
                      j, want[j].low_time, seen[j].low_time);
               errors++;
            end
            if (seen[j].high_time !== want[j].high_time) begin
               $error("high_time_%0d: expected %0d, actual %0d",
                      j, want[j].high_time, seen[j].high_time);
               errors++;
            end
         end
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset;
   int unsigned    cycle_count = 0;
   int             items_sent = 0;
   int             burst_left = 4;
   stall_mode_type stall_mode = STALL_NONE;

   frame_time_scoreboard frame_times = new();

   pwmhl_req_if req_bus ();
   pwmhl_rsp_if rsp_bus ();

   pwm_high_low_time_extract dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #10 clock = ~clock;

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Stall the result side on a pattern re-drawn when cycle_count[7:0] wraps
   always @(posedge clock) begin
      if (cycle_count[7:0] == 8'd0)
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:   rsp_bus.ready <= 1'b1;
         STALL_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
         STALL_SPARSE: rsp_bus.ready <= (cycle_count[1:0] == 2'd3);
         default:      rsp_bus.ready <= (cycle_count[5:0] >= 6'd40);
      endcase
   end

   // Check every result transfer against the oldest expected frame
   always @(posedge clock) begin : result_monitor
      frame_result_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen[0].low_time  = rsp_bus.low_time_0;
         seen[0].high_time = rsp_bus.high_time_0;
         seen[1].low_time  = rsp_bus.low_time_1;
         seen[1].high_time = rsp_bus.high_time_1;
         seen[2].low_time  = rsp_bus.low_time_2;
         seen[2].high_time = rsp_bus.high_time_2;
         seen[3].low_time  = rsp_bus.low_time_3;
         seen[3].high_time = rsp_bus.high_time_3;
         frame_times.check_times(seen);
      end
   end

   // Hold valid low for a random gap after each burst, or drain all results
   task automatic pace_sender(input bit drain);
      int gap;
      if (drain) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (frame_times.pending() != 0);
      end else begin
         burst_left--;
         if (burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 12);
         end
      end
   endtask

   // Offer one capture record and wait for its transfer
   task automatic transfer_record(input bit first, input logic [PIN_COUNT-1:0] init,
                                  input logic [IVL_WIDTH-1:0] ivl,
                                  input logic [PIN_COUNT-1:0] levels, input bit last);
      req_bus.valid          <= 1'b1;
      req_bus.first_record   <= first;
      req_bus.initial_pins   <= init;
      req_bus.interval_count <= ivl;
      req_bus.pin_values     <= levels;
      req_bus.last_record    <= last;
      do @(posedge clock); while (!req_bus.ready);
      frame_times.note_record(first, init, ivl, levels, last);
      items_sent++;
      pace_sender(items_sent == DRAIN_POINT);
   endtask

   task automatic run_directed();
      // records with no first record after reset: levels start at zero
      transfer_record(1'b0, 4'hF, 16'd1, 4'hF, 1'b0);
      transfer_record(1'b0, 4'h0, 16'hFFFF, 4'h0, 1'b1);
      // records after the last one keep accumulating
      transfer_record(1'b0, 4'hA, 16'd5, 4'h5, 1'b1);
      // one-record frame: first and last together
      transfer_record(1'b1, 4'hF, 16'hFFFF, 4'h0, 1'b1);
      // periods still in progress at the last record
      transfer_record(1'b1, 4'h0, 16'd0, 4'hF, 1'b0);
      transfer_record(1'b0, 4'h0, 16'd0, 4'h3, 1'b0);
      transfer_record(1'b0, 4'h0, 16'h8000, 4'h0, 1'b1);
      // long frame of full intervals: the open period of every pin saturates
      transfer_record(1'b1, 4'h5, 16'h1234, 4'hA, 1'b0);
      for (int k = 0; k < 17; k++)
         transfer_record(1'b0, 4'($urandom_range(0, 15)), 16'hFFFF, 4'hA, k == 16);
   endtask

   task automatic run_random();
      int                   kind;
      int                   flen;
      bit                   first;
      bit                   last;
      logic [PIN_COUNT-1:0] levels;
      logic [IVL_WIDTH-1:0] ivl;
      while (items_sent < RANDOM_STOP) begin
         kind = $urandom_range(0, 99);
         if (kind >= 94)
            flen = $urandom_range(17, 22);
         else if ($urandom_range(0, 11) == 0)
            flen = $urandom_range(13, 20);
         else
            flen = $urandom_range(1, 12);
         levels = 4'($urandom_range(0, 15));
         for (int k = 0; k < flen; k++) begin
            first = (k == 0);
            last = (k == flen - 1);
            // break some frames: no first record, no last record, or stray flags
            if (kind < 6)
               first = 1'b0;
            else if (kind < 11)
               last = 1'b0;
            else if (kind < 16) begin
               first = ($urandom_range(0, 5) == 0);
               last = ($urandom_range(0, 5) == 0);
            end
            if (kind >= 94) begin
               // steady levels and long intervals drive the sums to saturation
               ivl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF;
               if ($urandom_range(0, 9) == 0)
                  levels = 4'($urandom_range(0, 15));
            end else begin
               case ($urandom_range(0, 7))
                  0:       ivl = '0;
                  1:       ivl = 16'hFFFF;
                  2, 3:    ivl = 16'($urandom);
                  default: ivl = 16'($urandom_range(1, 500));
               endcase
               if ($urandom_range(0, 2) != 0)
                  levels = levels ^ 4'($urandom_range(0, 15));
            end
            transfer_record(first, 4'($urandom_range(0, 15)), ivl, levels, last);
         end
      end
   endtask

   initial begin
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.first_record   <= 1'b0;
      req_bus.initial_pins   <= '0;
      req_bus.interval_count <= '0;
      req_bus.pin_values     <= '0;
      req_bus.last_record    <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      // drain outstanding frames, then watch for stray results
      pace_sender(1'b1);
      repeat (8) @(posedge clock);
      if (frame_times.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
